FILE: src/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// nfsa_pkg
// shared widths, defaults, status codes and fsm encoding for the
// next-fit slab slot allocator
// ----------------------------------------------------------------------------
package nfsa_pkg;

   localparam int HANDLE_W = 10;
   localparam int STRIDE_W = 6;

   localparam int DEF_SLOTS_PER_SLAB = 64;
   localparam int DEF_MAX_SLABS      = 16;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_FREE = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

FILE: src/next_fit_slab_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// next_fit_slab_slot_allocator_top
// slab slot allocator: per-slab used bitmap and next-fit pointer held in one
// synchronous memory, searched newest slab first, one slab per cycle
// ----------------------------------------------------------------------------
// One request item is handled at a time and yields one response item. An
// allocate examines one slab after another, newest first, and a valid free
// reads its slab and then writes it back. The slab memory delivers one slab
// bitmap and its pointer per cycle through a single registered read port. The
// response sits in an output register, so a new request is taken while it
// waits. Slab entries are only read below the count of created slabs, so the
// memory needs no clearing after reset.
module next_fit_slab_slot_allocator_top #(
   parameter int SLOTS_PER_SLAB = nfsa_pkg::DEF_SLOTS_PER_SLAB,
   parameter int MAX_SLABS      = nfsa_pkg::DEF_MAX_SLABS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // op [0], block_handle [10:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // granted_handle [9:0], status [11:10]
);

   localparam int PTR_W  = $clog2(SLOTS_PER_SLAB);
   localparam int SLAB_W = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLABS + 1);
   localparam int MEM_W  = SLOTS_PER_SLAB + PTR_W;
   localparam int HW     = nfsa_pkg::HANDLE_W;

   function automatic logic [HW-1:0] make_handle(input logic [7:0] slab,
                                                 input logic [PTR_W-1:0] pos);
      return HW'({slab, nfsa_pkg::STRIDE_W'(pos)});
   endfunction

   nfsa_pkg::state_type  state_ff, state_in;
   logic [SLAB_W-1:0]    cur_ff, cur_in;
   logic [PTR_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     created_ff, created_in;
   logic [HW-1:0]        res_handle_ff, res_handle_in;
   nfsa_pkg::status_type res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0]        rsp_handle_ff, rsp_handle_in;
   nfsa_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [MEM_W-1:0]     mem_ff [MAX_SLABS];
   logic [MEM_W-1:0]     rd_data_ff;
   logic                 rd_en;
   logic [SLAB_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [SLAB_W-1:0]    wr_addr;
   logic [MEM_W-1:0]     wr_data;

   logic                      req_op;
   logic [3:0]                req_slab;
   logic [nfsa_pkg::STRIDE_W-1:0] req_pos;
   logic                      free_ok;
   logic                      out_free;

   logic [SLOTS_PER_SLAB-1:0] used;
   logic [PTR_W-1:0]          ptr;
   logic [SLOTS_PER_SLAB-1:0] free_map;
   logic [SLOTS_PER_SLAB-1:0] ge_mask;
   logic [SLOTS_PER_SLAB-1:0] hi_map;
   logic [SLOTS_PER_SLAB-1:0] sel_map;
   logic [SLOTS_PER_SLAB-1:0] pick_hot;
   logic [PTR_W-1:0]          pick_idx;
   logic [PTR_W-1:0]          pick_next;
   logic                      found;
   logic                      room;

   assign req_op   = req_tdata[0];
   assign req_slab = req_tdata[10:7];
   assign req_pos  = req_tdata[6:1];
   assign free_ok  = (8'(req_slab) < 8'(created_ff)) && (8'(req_slab) < 8'(MAX_SLABS))
                     && (8'(req_pos) < 8'(SLOTS_PER_SLAB));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign room     = created_ff < CNT_W'(MAX_SLABS);

   assign req_tready = (state_ff == nfsa_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_status_ff, rsp_handle_ff};

   // first free slot at or after the pointer, else the lowest free slot
   assign used      = rd_data_ff[SLOTS_PER_SLAB-1:0];
   assign ptr       = rd_data_ff[MEM_W-1:SLOTS_PER_SLAB];
   assign free_map  = ~used;
   assign ge_mask   = ~((SLOTS_PER_SLAB'(1) << ptr) - SLOTS_PER_SLAB'(1));
   assign hi_map    = free_map & ge_mask;
   assign sel_map   = (|hi_map) ? hi_map : free_map;
   assign pick_hot  = sel_map & (~sel_map + SLOTS_PER_SLAB'(1));
   assign found     = |free_map;
   assign pick_next = (pick_idx == PTR_W'(SLOTS_PER_SLAB - 1)) ? '0 : pick_idx + PTR_W'(1);

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < SLOTS_PER_SLAB; i++) begin
         if (pick_hot[i]) begin
            pick_idx = pick_idx | PTR_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      created_in    = created_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = {PTR_W'(1), SLOTS_PER_SLAB'(1)};

      unique case (state_ff)
         nfsa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               res_handle_in = '0;
               res_status_in = nfsa_pkg::STATUS_OK;
               state_in      = nfsa_pkg::ST_DONE;
               if (!req_op) begin
                  if (created_ff == '0) begin
                     // first slab, slot 0
                     wr_en      = 1'b1;
                     wr_addr    = '0;
                     created_in = CNT_W'(1);
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = SLAB_W'(created_ff - CNT_W'(1));
                     cur_in   = SLAB_W'(created_ff - CNT_W'(1));
                     state_in = nfsa_pkg::ST_SCAN;
                  end
               end else if (free_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = SLAB_W'(req_slab);
                  cur_in   = SLAB_W'(req_slab);
                  pos_in   = PTR_W'(req_pos);
                  state_in = nfsa_pkg::ST_FREE;
               end else begin
                  res_status_in = nfsa_pkg::STATUS_BAD_FREE;
               end
            end
         end
         nfsa_pkg::ST_SCAN: begin
            if (found) begin
               wr_en         = 1'b1;
               wr_data       = {pick_next, used | pick_hot};
               res_handle_in = make_handle(8'(cur_ff), pick_idx);
               state_in      = nfsa_pkg::ST_DONE;
            end else if (cur_ff == '0) begin
               state_in = nfsa_pkg::ST_DONE;
               if (room) begin
                  // open a new slab, slot 0
                  wr_en         = 1'b1;
                  wr_addr       = SLAB_W'(created_ff);
                  created_in    = created_ff + CNT_W'(1);
                  res_handle_in = make_handle(8'(created_ff), '0);
               end else begin
                  res_status_in = nfsa_pkg::STATUS_FULL;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = cur_ff - SLAB_W'(1);
               cur_in  = cur_ff - SLAB_W'(1);
            end
         end
         nfsa_pkg::ST_FREE: begin
            wr_en    = 1'b1;
            wr_data  = {pos_ff, used & ~(SLOTS_PER_SLAB'(1) << pos_ff)};
            state_in = nfsa_pkg::ST_DONE;
         end
         nfsa_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = res_handle_ff;
               rsp_status_in = res_status_ff;
               state_in      = nfsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nfsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfsa_pkg::ST_IDLE;
         created_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         created_ff   <= created_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_created_cap: assert property (@(posedge clock) disable iff (reset)
      created_ff <= CNT_W'(MAX_SLABS))
      else $error("slab count above cap");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) <= created_ff))
      else $error("slab write beyond created slabs");

   a_full_only_at_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfsa_pkg::ST_DONE && res_status_ff == nfsa_pkg::STATUS_FULL)
      |-> (created_ff == CNT_W'(MAX_SLABS)))
      else $error("full status below slab cap");

   a_scan_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfsa_pkg::ST_SCAN) |-> (CNT_W'(cur_ff) < created_ff))
      else $error("scan of uncreated slab");

endmodule

FILE: sim/next_fit_slab_slot_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_slab_slot_allocator_top_tb
// Sends allocate and free items into the slab slot allocator and keeps its own
// copy of the per-slab used bitmaps, next-fit pointers and created-slab count.
// Every response is checked against that prediction, field by field. A short
// directed run comes first. It is followed by a fill phase that reaches the
// slab cap and a mixed phase of allocates and frees. Both sides idle at random,
// and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module next_fit_slab_slot_allocator_top_tb;

   localparam int SLOTS          = nfsa_pkg::DEF_SLOTS_PER_SLAB;
   localparam int SLABS          = nfsa_pkg::DEF_MAX_SLABS;
   localparam int HANDLE_W       = nfsa_pkg::HANDLE_W;
   localparam int STRIDE_W       = nfsa_pkg::STRIDE_W;
   localparam int HANDLE_STRIDE  = 64;
   localparam logic OP_ALLOC     = 1'b0;
   localparam logic OP_FREE      = 1'b1;
   localparam int FILL_ITEMS     = 1200;
   localparam int MIXED_ITEMS    = 450;
   localparam int TAIL_ITEMS     = 150;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic                op;
   } slab_req_type;

   typedef struct packed {
      nfsa_pkg::status_type status;
      logic [HANDLE_W-1:0]  granted;
   } slab_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // op [0], block_handle [10:1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // granted_handle [9:0], status [11:10]

   logic [SLOTS-1:0]    slab_used [SLABS];
   logic [STRIDE_W-1:0] slab_next [SLABS];
   int                  slabs_open;

   slab_req_type req_pending[$];
   slab_rsp_type expected_rsp[$];
   slab_req_type next_req;
   slab_req_type seen_req;
   slab_rsp_type want_rsp;

   int item_total     = 0;
   int req_gap        = 0;
   int rsp_gap        = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int rsp_count      = 0;
   int idle_cycles    = 0;
   int mismatches     = 0;
   int alloc_count    = 0;
   int free_count     = 0;
   int refused_count  = 0;
   int rejected_count = 0;

   next_fit_slab_slot_allocator_top #(
      .SLOTS_PER_SLAB (SLOTS),
      .MAX_SLABS      (SLABS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // next-fit search, newest slab first, opening a new slab when all are full
   function automatic slab_rsp_type predict_slot(input slab_req_type item);
      slab_rsp_type res;
      int           slab;
      int           pos;
      int           k;
      bit           found;
      res.granted = '0;
      res.status  = nfsa_pkg::STATUS_OK;
      found       = 1'b0;
      if (item.op == OP_ALLOC) begin
         for (slab = slabs_open - 1; slab >= 0 && !found; slab--) begin
            pos = int'(slab_next[slab]) % SLOTS;
            for (k = 0; k < SLOTS && !found; k++) begin
               if (!slab_used[slab][pos]) begin
                  slab_used[slab][pos] = 1'b1;
                  slab_next[slab]      = STRIDE_W'((pos + 1) % SLOTS);
                  res.granted          = HANDLE_W'(slab * HANDLE_STRIDE + pos);
                  found                = 1'b1;
               end else begin
                  pos = (pos + 1) % SLOTS;
               end
            end
         end
         if (!found) begin
            if (slabs_open < SLABS) begin
               slab_used[slabs_open] = SLOTS'(1);
               slab_next[slabs_open] = STRIDE_W'(1 % SLOTS);
               res.granted           = HANDLE_W'(slabs_open * HANDLE_STRIDE);
               slabs_open++;
            end else begin
               res.status = nfsa_pkg::STATUS_FULL;
            end
         end
      end else begin
         slab = int'(item.handle) / HANDLE_STRIDE;
         pos  = int'(item.handle) % HANDLE_STRIDE;
         if (slab < slabs_open && slab < SLABS && pos < SLOTS) begin
            slab_used[slab][pos] = 1'b0;
            slab_next[slab]      = STRIDE_W'(pos);
         end else begin
            res.status = nfsa_pkg::STATUS_BAD_FREE;
         end
      end
      return res;
   endfunction

   task automatic queue_req(input logic op, input int handle);
      slab_req_type item;
      item.op     = op;
      item.handle = HANDLE_W'(handle);
      req_pending.push_back(item);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            seen_req = req_tdata[HANDLE_W:0];
            if (seen_req.op == OP_ALLOC) alloc_count++;
            else free_count++;
            expected_rsp.push_back(predict_slot(seen_req));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (req_pending.size() > 0) begin
               next_req = req_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, next_req};
               if (req_pending.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
                  req_gap <= $urandom_range(1, 4);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with one long hold to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_count < item_total - TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
         rsp_gap    <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count <= rsp_count + 1;
         if (rsp_tdata[11:10] == nfsa_pkg::STATUS_FULL) refused_count++;
         if (rsp_tdata[11:10] == nfsa_pkg::STATUS_BAD_FREE) rejected_count++;
         if (expected_rsp.size() == 0) begin
            $error("unexpected item: granted_handle %0d status %0d",
                   rsp_tdata[9:0], rsp_tdata[11:10]);
            mismatches++;
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_tdata[9:0] !== want_rsp.granted) begin
               $error("granted_handle: expected %0d, actual %0d",
                      want_rsp.granted, rsp_tdata[9:0]);
               mismatches++;
            end
            if (rsp_tdata[11:10] !== want_rsp.status) begin
               $error("status: expected %0d, actual %0d",
                      want_rsp.status, rsp_tdata[11:10]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d responses outstanding",
                  idle_cycles, expected_rsp.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int s;
      int n;
      for (s = 0; s < SLABS; s++) begin
         slab_used[s] = '0;
         slab_next[s] = '0;
      end
      slabs_open = 0;

      // frees before any slab exists
      queue_req(OP_FREE, 0);
      queue_req(OP_FREE, 1023);
      // first allocate opens slab 0, handle bits ignored
      queue_req(OP_ALLOC, 1023);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_ALLOC, 10'h155);
      // free moves the pointer back to the freed slot
      queue_req(OP_FREE, 1);
      queue_req(OP_ALLOC, 10'h2aa);
      // free of a slot not in use still moves the pointer
      queue_req(OP_FREE, 40);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_FREE, 63);
      queue_req(OP_ALLOC, 0);
      // pointer wraps past the top slot
      queue_req(OP_ALLOC, 0);
      // frees in slabs not yet created, then frees and allocates in slab 0
      queue_req(OP_FREE, HANDLE_STRIDE);
      queue_req(OP_FREE, 15 * HANDLE_STRIDE + 63);
      queue_req(OP_FREE, 0);
      queue_req(OP_FREE, 2);
      queue_req(OP_ALLOC, 1023);
      queue_req(OP_ALLOC, 512);

      // fill phase: mostly allocates, runs every slab full and into the cap
      for (n = 0; n < FILL_ITEMS; n++) begin
         if ($urandom_range(0, 31) == 0) queue_req(OP_FREE, $urandom_range(0, 1023));
         else queue_req(OP_ALLOC, $urandom_range(0, 1023));
      end
      // mixed phase: scattered frees and refills across all slabs
      for (n = 0; n < MIXED_ITEMS; n++)
         queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023));
      item_total = req_pending.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (req_pending.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d allocates and %0d frees, %0d slabs opened", alloc_count,
               free_count, slabs_open);
      $display("%0d allocates refused at the slab cap, %0d frees rejected",
               refused_count, rejected_count);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/nfsa_pkg.sv
src/next_fit_slab_slot_allocator_top.sv
sim/next_fit_slab_slot_allocator_top_tb.sv
